// ===== rtl/semt_pkg.sv =====
// ----------------------------------------------------------------------------
// semt_pkg
// Types and constants shared by the serial encoder multi-turn tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package semt_pkg;

  localparam int ANGLE_BITS     = 10;
  localparam int TRAILER_PULSES = 7;
  localparam int FRAME_PULSES   = ANGLE_BITS + TRAILER_PULSES;
  localparam int PULSE_W        = $clog2(FRAME_PULSES + 1);
  localparam int LAP_W          = 8;
  localparam int POS_W          = 18;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [ANGLE_BITS-1:0] RST_ANGLE_OFFSET   = '0;
  localparam logic [LAP_W-1:0]      RST_MAX_LAPS       = LAP_W'(1);
  localparam logic [ANGLE_BITS-1:0] RST_WRAP_THRESHOLD = ANGLE_BITS'(950);
  localparam logic                  RST_RAW_MODE       = 1'b0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ANGLE_OFFSET   = 2'd0,
    CFG_MAX_LAPS       = 2'd1,
    CFG_WRAP_THRESHOLD = 2'd2,
    CFG_RAW_MODE       = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ACT_PULSE    = 1'b0,
    ACT_LOAD_LAP = 1'b1
  } action_t;

  typedef struct packed {
    logic             action;
    logic             data_bit;
    logic [LAP_W-1:0] lap_value;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]      position;
    logic [ANGLE_BITS-1:0] angle;
    logic [LAP_W-1:0]      lap;
  } out_item_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_offset;
    logic [LAP_W-1:0]      max_laps;
    logic [ANGLE_BITS-1:0] wrap_threshold;
    logic                  raw_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/serial_encoder_multiturn_tracker.sv =====
// ----------------------------------------------------------------------------
// serial_encoder_multiturn_tracker
// Multi-turn position tracker for a synchronous-serial absolute encoder.
// ----------------------------------------------------------------------------
// Each input beat is either one encoder clock pulse with its sampled data bit
// or a lap load. A frame is 10 data pulses, MSB first, then 7 trailer pulses.
// The last pulse of a frame produces one output beat: multi-turn position,
// angle (offset-corrected unless raw mode is set) and lap count. Pulses inside
// a frame and lap loads produce no output.
// Throughput: one input beat per cycle while in_ready is high. The output beat
// is valid the cycle after the frame's last pulse is accepted; all work is done
// by the combinational path from the input port into the output register.
// Stall: a single output register holds the result; in_ready drops only while
// that register is full and out_ready is low.
// Reset (synchronous): frame position, shift word, angle history and lap count
// clear, registers take their defaults, the output register empties.
// Configuration writes are taken in any cycle, meant only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_encoder_multiturn_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire semt_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output semt_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [semt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [semt_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  semt_pkg::cfg_t      cfg;
  semt_pkg::out_item_t result;
  logic                result_valid;
  logic                accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  semt_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  semt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .item         (in_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/semt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// semt_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module semt_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [semt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [semt_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  output semt_pkg::cfg_t                           cfg
);

  semt_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.angle_offset   <= semt_pkg::RST_ANGLE_OFFSET;
      regs.max_laps       <= semt_pkg::RST_MAX_LAPS;
      regs.wrap_threshold <= semt_pkg::RST_WRAP_THRESHOLD;
      regs.raw_mode       <= semt_pkg::RST_RAW_MODE;
    end else if (cfg_wr_en) begin
      unique case (semt_pkg::cfg_index_t'(cfg_index))
        semt_pkg::CFG_ANGLE_OFFSET: begin
          regs.angle_offset <= cfg_wr_data[semt_pkg::ANGLE_BITS-1:0];
        end
        semt_pkg::CFG_MAX_LAPS: begin
          regs.max_laps <= cfg_wr_data[semt_pkg::LAP_W-1:0];
        end
        semt_pkg::CFG_WRAP_THRESHOLD: begin
          regs.wrap_threshold <= cfg_wr_data[semt_pkg::ANGLE_BITS-1:0];
        end
        semt_pkg::CFG_RAW_MODE: begin
          regs.raw_mode <= cfg_wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== rtl/semt_core.sv =====
// ----------------------------------------------------------------------------
// semt_core
// Frame assembly, offset correction and lap tracking for one beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module semt_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire semt_pkg::cfg_t      cfg,
  input  wire logic                accept,
  input  wire semt_pkg::in_item_t  item,
  output logic                     result_valid,
  output semt_pkg::out_item_t      result
);

  localparam int AB = semt_pkg::ANGLE_BITS;
  localparam int LW = semt_pkg::LAP_W;
  localparam int PW = semt_pkg::PULSE_W;

  logic [PW-1:0] pulse_count, pulse_count_next;
  logic [AB-1:0] shift_word, shift_word_next;
  logic [AB-1:0] last_angle, last_angle_next;
  logic [LW-1:0] lap_count, lap_count_next;

  logic          is_pulse;
  logic          frame_end;
  logic [AB-1:0] raw;
  logic [AB-1:0] corr;
  logic [AB-1:0] angle_out;
  logic          laps_on;
  logic [LW-1:0] lap_top;
  logic          count_up;
  logic          count_down;
  logic [LW-1:0] lap_tracked;

  assign is_pulse  = (semt_pkg::action_t'(item.action) == semt_pkg::ACT_PULSE);
  assign frame_end = (pulse_count == PW'(semt_pkg::FRAME_PULSES - 1));

  // data pulses shift in MSB first, trailer pulses leave the word alone
  assign shift_word_next = (pulse_count < PW'(AB)) ?
                           {shift_word[AB-2:0], item.data_bit} : shift_word;
  assign raw     = shift_word_next;
  assign corr    = raw - cfg.angle_offset;
  assign laps_on = (cfg.max_laps > LW'(1));
  assign lap_top = cfg.max_laps - LW'(1);

  // half crossing: MSB tells whether an angle sits in the lower half turn
  assign count_up   = (last_angle > cfg.wrap_threshold) && !corr[AB-1] && last_angle[AB-1];
  assign count_down = (corr > cfg.wrap_threshold) && corr[AB-1] && !last_angle[AB-1];

  always_comb begin
    lap_tracked = lap_count;
    if (count_up) begin
      lap_tracked = (lap_count >= lap_top) ? '0 : lap_count + LW'(1);
    end else if (count_down) begin
      lap_tracked = (lap_count == '0) ? lap_top : lap_count - LW'(1);
    end
  end

  always_comb begin
    pulse_count_next = pulse_count;
    last_angle_next  = last_angle;
    lap_count_next   = lap_count;
    angle_out        = cfg.raw_mode ? raw : corr;
    if (accept) begin
      if (!is_pulse) begin
        if (item.lap_value < cfg.max_laps) begin
          lap_count_next = item.lap_value;
        end
      end else if (frame_end) begin
        pulse_count_next = '0;
        if (!cfg.raw_mode) begin
          last_angle_next = corr;
          if (laps_on) begin
            lap_count_next = lap_tracked;
          end
        end
      end else begin
        pulse_count_next = pulse_count + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count <= '0;
      shift_word  <= '0;
      last_angle  <= '0;
      lap_count   <= '0;
    end else begin
      pulse_count <= pulse_count_next;
      last_angle  <= last_angle_next;
      lap_count   <= lap_count_next;
      if (accept && is_pulse) begin
        shift_word <= shift_word_next;
      end
    end
  end

  assign result_valid    = accept && is_pulse && frame_end;
  assign result.angle    = angle_out;
  assign result.lap      = lap_count_next;
  assign result.position = laps_on ?
      semt_pkg::POS_W'({lap_count_next, angle_out}) :
      semt_pkg::POS_W'(angle_out);

endmodule

`default_nettype wire

// ===== rtl/semt_checker.sv =====
// ----------------------------------------------------------------------------
// semt_checker
// Port-level assertions for the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module semt_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire semt_pkg::out_item_t out_data
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // single result slot: a full stalled slot blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output slot is full");

  a_pos_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.position[semt_pkg::ANGLE_BITS-1:0] == out_data.angle)
    else $error("position low bits differ from angle");

endmodule

bind serial_encoder_multiturn_tracker semt_checker u_semt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
